// File: rtl/current_loop_iir_pwm_defines.svh
// Assertion macros for the current loop controller.
// Included by files that carry concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef CURRENT_LOOP_IIR_PWM_DEFINES_SVH
`define CURRENT_LOOP_IIR_PWM_DEFINES_SVH

`ifndef SYNTHESIS
`define CLPWM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("current_loop_iir_pwm: assertion failed");
`define CLPWM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("current_loop_iir_pwm: implication failed");
`else
`define CLPWM_ASSERT(lbl, prop)
`define CLPWM_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

// File: rtl/clpwm_pkg.sv
// Shared widths, constants and control types of the current loop controller.
// No dependencies; used by clpwm_mac and current_loop_iir_pwm.
package clpwm_pkg;

  localparam int ADC_BITS_DEF = 12;

  localparam int DIGIT_W    = 4;
  localparam int COEF_W     = 16;
  localparam int NUM_DIGITS = COEF_W / DIGIT_W;
  localparam int CDIG_W     = $clog2(NUM_DIGITS);
  localparam int NUM_TAPS   = 8;
  localparam int TAP_W      = $clog2(NUM_TAPS);
  localparam int NUM_HIST   = 3;
  localparam int NUM_FBC    = 4;

  localparam int VOLT_W     = 32;
  localparam int VAL_W      = VOLT_W + 1;
  localparam int ACC_W      = 42;
  localparam int LOW_W      = COEF_W;
  localparam int FRAC_SHIFT = 12;
  localparam int RAW_W      = ACC_W + LOW_W - FRAC_SHIFT;

  localparam int PWM_SCALE_W = 32;
  localparam int PWM_DIGITS  = PWM_SCALE_W / DIGIT_W;
  localparam int CNT_W       = $clog2(PWM_DIGITS);
  localparam int PWM_OUT_W   = 16;

  localparam int DB_W     = 12;
  localparam int FBS_W    = 20;
  localparam int SAT_W    = 31;
  localparam int TOGGLE_W = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 64;

  localparam logic [COEF_W-1:0] REF_COEF   = COEF_W'(1 << FRAC_SHIFT);
  localparam logic [ACC_W-1:0]  ROUND_INIT = ACC_W'(1 << (FRAC_SHIFT - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_COEFS, REG_DRV_COEFS, REG_REF_DRIVE, REG_DEADBAND,
    REG_FB_SCALE, REG_SAT_LIMIT, REG_PWM_SCALE, REG_TOGGLE
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic en;
    logic shift;
  } mac_ctrl_t;

endpackage

// File: rtl/clpwm_mac.sv
// Digit-serial multiply-accumulate: one signed weight digit per cycle while enabled.
// Shift-right accumulator; low bits leave into a shift register. Uses clpwm_pkg.
module clpwm_mac
  import clpwm_pkg::*;
(
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic [ACC_W-1:0]         init_i,
  input  logic signed [VAL_W-1:0]  val_i,
  input  logic signed [DIGIT_W:0]  dig_i,
  output logic signed [ACC_W-1:0]  acc_o,
  output logic [LOW_W-1:0]         low_o
);

  localparam int PROD_W = VAL_W + DIGIT_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  acc_q;
  logic [LOW_W-1:0]         low_q;

  assign prod = PROD_W'(val_i) * PROD_W'(dig_i);
  assign sum  = acc_q + ACC_W'(prod);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= $signed(init_i);
      low_q <= '0;
    end else if (ctrl_i.en) begin
      if (ctrl_i.shift) begin
        acc_q <= sum >>> DIGIT_W;
        low_q <= {sum[DIGIT_W-1:0], low_q[LOW_W-1:DIGIT_W]};
      end else begin
        acc_q <= sum;
      end
    end
  end

  assign acc_o = acc_q;
  assign low_o = low_q;

endmodule

// File: rtl/current_loop_iir_pwm.sv
// Current loop difference-equation controller with saturated PWM output.
// Top level; uses clpwm_pkg, clpwm_mac and current_loop_iir_pwm_defines.svh.
//
// One ADC item per control tick. The first item after reset is stored as the zero
// offset and gives no result; the block is free again on the next cycle. Every later
// item is worked through in full before the block can take the next one: the offset,
// dead band and feedback scale, then the shared 33x5-bit digit multiplier (eight taps,
// reference included, times four 4-bit coefficient digits), then rounding and clamping,
// the magnitude, eight PWM digits through the same multiplier and the hand-over.
// The result sits in an output register, so a stalled result does not block the
// next item; the controller only waits at hand-over if the previous one is still held.
// Configuration writes are always taken.
`include "current_loop_iir_pwm_defines.svh"

module current_loop_iir_pwm
  import clpwm_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADC_BITS-1:0]   adc_code_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PWM_OUT_W-1:0]  pwm_compare_o,
  output logic                  direction_o,
  output logic                  deadband_hit_o,
  output logic signed [VOLT_W-1:0] drive_volts_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int DW = ADC_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_MAC, ST_CLAMP, ST_ABS, ST_PWM, ST_DONE
  } state_e;

  // configuration
  logic [NUM_FBC*COEF_W-1:0]  fb_coefs_q;
  logic [NUM_HIST*COEF_W-1:0] drv_coefs_q;
  logic signed [VOLT_W-1:0]   ref_drive_q;
  logic [DB_W-1:0]            deadband_q;
  logic [FBS_W-1:0]           fb_scale_q;
  logic [SAT_W-1:0]           sat_limit_q;
  logic [PWM_SCALE_W-1:0]     pwm_scale_q;
  logic [TOGGLE_W-1:0]        toggle_q;

  // controller state
  state_e                   state_q;
  logic [TAP_W-1:0]         tap_q;
  logic [CNT_W-1:0]         dig_q;
  logic                     cal_q;
  logic [ADC_BITS-1:0]      zero_q;
  logic [TOGGLE_W-1:0]      tick_q;
  logic                     ref_neg_q;
  logic                     ref_neg_item_q;
  logic signed [VOLT_W-1:0] drv_hist_q [NUM_HIST];
  logic signed [VOLT_W-1:0] fb_hist_q [NUM_HIST];
  logic                     out_valid_q;

  // item payload
  logic [ADC_BITS-1:0]      code_q;
  logic signed [VOLT_W-1:0] fb0_q;
  logic                     hit_q;
  logic signed [VOLT_W-1:0] drive_q;
  logic [VOLT_W-2:0]        mag_q;
  logic [PWM_OUT_W-1:0]     pwm_q;
  logic                     dir_q;
  logic                     hit_out_q;
  logic signed [VOLT_W-1:0] volts_q;

  logic                     in_fire;
  logic                     out_fire;
  logic [TOGGLE_W-1:0]      tick_inc;

  logic signed [DW-1:0]     diff;
  logic [DW-1:0]            diff_mag;
  logic                     hit_d;
  logic signed [63:0]       fb_prod;
  logic [32:0]              fb_prod_hi;
  logic signed [VOLT_W-1:0] fb_sat;
  logic signed [VOLT_W-1:0] fb0_d;

  logic signed [VAL_W-1:0]  ref_ext;
  logic signed [VAL_W-1:0]  tap_val [NUM_TAPS];
  logic [COEF_W-1:0]        tap_coef [NUM_TAPS];
  logic [COEF_W-1:0]        cur_coef;
  logic [DIGIT_W-1:0]       coef_dig;
  logic                     coef_msb;

  mac_ctrl_t                mac_ctrl;
  logic [ACC_W-1:0]         mac_init;
  logic signed [VAL_W-1:0]  mac_val;
  logic signed [DIGIT_W:0]  mac_dig;
  logic signed [ACC_W-1:0]  mac_acc;
  logic [LOW_W-1:0]         mac_low;

  logic signed [RAW_W-1:0]  drive_raw;
  logic signed [RAW_W-1:0]  lim_pos;
  logic signed [VOLT_W-1:0] lim_volts;
  logic signed [VOLT_W-1:0] drive_d;
  logic [PWM_OUT_W-1:0]     pwm_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign tick_inc    = tick_q + TOGGLE_W'(1);

  // feedback sample
  assign diff       = $signed({1'b0, code_q}) - $signed({1'b0, zero_q});
  assign diff_mag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign hit_d      = 32'(diff_mag) < 32'(deadband_q);
  assign fb_prod    = 64'(diff) * 64'($signed({1'b0, fb_scale_q}));
  assign fb_prod_hi = fb_prod[63:31];

  always_comb begin
    if (fb_prod_hi == '0 || fb_prod_hi == '1) begin
      fb_sat = fb_prod[VOLT_W-1:0];
    end else if (fb_prod[63]) begin
      fb_sat = {1'b1, {(VOLT_W-1){1'b0}}};
    end else begin
      fb_sat = {1'b0, {(VOLT_W-1){1'b1}}};
    end
    fb0_d = hit_d ? '0 : fb_sat;
  end

  // tap values and weights
  assign ref_ext = VAL_W'(ref_drive_q);

  always_comb begin
    tap_val[0]  = ref_neg_item_q ? -ref_ext : ref_ext;
    tap_coef[0] = REF_COEF;
    for (int i = 0; i < NUM_HIST; i++) begin
      tap_val[1+i]  = VAL_W'(drv_hist_q[i]);
      tap_coef[1+i] = drv_coefs_q[i*COEF_W +: COEF_W];
    end
    for (int i = 0; i < NUM_FBC; i++) begin
      tap_val[1+NUM_HIST+i]  = (i == 0) ? VAL_W'(fb0_q) : VAL_W'(fb_hist_q[(i > 0) ? i-1 : 0]);
      tap_coef[1+NUM_HIST+i] = fb_coefs_q[i*COEF_W +: COEF_W];
    end
  end

  assign cur_coef = tap_coef[tap_q];
  assign coef_dig = cur_coef[dig_q[CDIG_W-1:0]*DIGIT_W +: DIGIT_W];
  assign coef_msb = (dig_q[CDIG_W-1:0] == CDIG_W'(NUM_DIGITS-1)) ? cur_coef[COEF_W-1] : 1'b0;

  always_comb begin
    mac_ctrl = '0;
    mac_init = ROUND_INIT;
    mac_val  = tap_val[tap_q];
    mac_dig  = $signed({coef_msb, coef_dig});
    case (state_q)
      ST_PREP: begin
        mac_ctrl.load = 1'b1;
      end
      ST_MAC: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.shift = (tap_q == TAP_W'(NUM_TAPS-1));
      end
      ST_CLAMP: begin
        mac_ctrl.load = 1'b1;
        mac_init      = '0;
      end
      ST_PWM: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.shift = 1'b1;
        mac_val        = $signed({{(VAL_W-VOLT_W+1){1'b0}}, mag_q});
        mac_dig        = $signed({1'b0, pwm_scale_q[dig_q*DIGIT_W +: DIGIT_W]});
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  clpwm_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .init_i (mac_init),
    .val_i  (mac_val),
    .dig_i  (mac_dig),
    .acc_o  (mac_acc),
    .low_o  (mac_low)
  );

  // round, clamp, PWM saturation
  assign drive_raw = $signed({mac_acc, mac_low[LOW_W-1:FRAC_SHIFT]});
  assign lim_pos   = $signed(RAW_W'(sat_limit_q));
  assign lim_volts = $signed({1'b0, sat_limit_q});

  always_comb begin
    if (drive_raw > lim_pos) begin
      drive_d = lim_volts;
    end else if (drive_raw < -lim_pos) begin
      drive_d = -lim_volts;
    end else begin
      drive_d = drive_raw[VOLT_W-1:0];
    end
    pwm_d = (|mac_acc[ACC_W-1:PWM_OUT_W]) ? '1 : mac_acc[PWM_OUT_W-1:0];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_coefs_q  <= '0;
      drv_coefs_q <= '0;
      ref_drive_q <= '0;
      deadband_q  <= DB_W'(12);
      fb_scale_q  <= FBS_W'(53);
      sat_limit_q <= '1;
      pwm_scale_q <= '0;
      toggle_q    <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_FB_COEFS:  fb_coefs_q  <= cfg_data_i[NUM_FBC*COEF_W-1:0];
        REG_DRV_COEFS: drv_coefs_q <= cfg_data_i[NUM_HIST*COEF_W-1:0];
        REG_REF_DRIVE: ref_drive_q <= $signed(cfg_data_i[VOLT_W-1:0]);
        REG_DEADBAND:  deadband_q  <= cfg_data_i[DB_W-1:0];
        REG_FB_SCALE:  fb_scale_q  <= cfg_data_i[FBS_W-1:0];
        REG_SAT_LIMIT: sat_limit_q <= cfg_data_i[SAT_W-1:0];
        REG_PWM_SCALE: pwm_scale_q <= cfg_data_i[PWM_SCALE_W-1:0];
        REG_TOGGLE:    toggle_q    <= cfg_data_i[TOGGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      tap_q          <= '0;
      dig_q          <= '0;
      cal_q          <= 1'b1;
      zero_q         <= '0;
      tick_q         <= '0;
      ref_neg_q      <= 1'b0;
      ref_neg_item_q <= 1'b0;
      out_valid_q    <= 1'b0;
      pwm_q          <= '0;
      dir_q          <= 1'b0;
      hit_out_q      <= 1'b0;
      volts_q        <= '0;
      for (int i = 0; i < NUM_HIST; i++) begin
        drv_hist_q[i] <= '0;
        fb_hist_q[i]  <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && !out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ref_neg_item_q <= ref_neg_q;
            if (tick_inc >= toggle_q) begin
              tick_q    <= '0;
              ref_neg_q <= !ref_neg_q;
            end else begin
              tick_q <= tick_inc;
            end
            if (cal_q) begin
              cal_q  <= 1'b0;
              zero_q <= adc_code_i;
              for (int i = 0; i < NUM_HIST; i++) begin
                drv_hist_q[i] <= '0;
                fb_hist_q[i]  <= '0;
              end
            end else begin
              state_q <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          tap_q   <= '0;
          dig_q   <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          if (tap_q == TAP_W'(NUM_TAPS-1)) begin
            tap_q <= '0;
            if (dig_q == CNT_W'(NUM_DIGITS-1)) begin
              dig_q   <= '0;
              state_q <= ST_CLAMP;
            end else begin
              dig_q <= dig_q + CNT_W'(1);
            end
          end else begin
            tap_q <= tap_q + TAP_W'(1);
          end
        end
        ST_CLAMP: begin
          for (int i = NUM_HIST-1; i > 0; i--) begin
            drv_hist_q[i] <= drv_hist_q[i-1];
            fb_hist_q[i]  <= fb_hist_q[i-1];
          end
          drv_hist_q[0] <= drive_d;
          fb_hist_q[0]  <= fb0_q;
          state_q       <= ST_ABS;
        end
        ST_ABS: begin
          dig_q   <= '0;
          state_q <= ST_PWM;
        end
        ST_PWM: begin
          if (dig_q == CNT_W'(PWM_DIGITS-1)) begin
            dig_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            dig_q <= dig_q + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (out_fire) begin
            out_valid_q <= 1'b1;
            pwm_q       <= pwm_d;
            dir_q       <= !drive_q[VOLT_W-1];
            hit_out_q   <= hit_q;
            volts_q     <= drive_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      code_q <= adc_code_i;
    end
    if (state_q == ST_PREP) begin
      fb0_q <= fb0_d;
      hit_q <= hit_d;
    end
    if (state_q == ST_CLAMP) begin
      drive_q <= drive_d;
    end
    if (state_q == ST_ABS) begin
      mag_q <= (VOLT_W-1)'(drive_q[VOLT_W-1] ? -drive_q : drive_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_compare_o  = pwm_q;
  assign direction_o    = dir_q;
  assign deadband_hit_o = hit_out_q;
  assign drive_volts_o  = volts_q;

  `CLPWM_ASSERT(a_out_from_done, $rose(out_valid_o) |-> $past(state_q == ST_DONE))
  `CLPWM_ASSERT_IMPLY(a_prep_after_cal, state_q == ST_PREP, !cal_q)
  `CLPWM_ASSERT_IMPLY(a_drive_clamped, state_q == ST_ABS, (drive_q <= lim_volts) && (drive_q >= -lim_volts))
  `CLPWM_ASSERT_IMPLY(a_mac_digit_range, state_q == ST_MAC, dig_q < CNT_W'(NUM_DIGITS))

endmodule

// File: bench/current_loop_iir_pwm_tb.sv
// Self-checking bench for current_loop_iir_pwm: random idle on both channels,
// register settings swept between phases, every result checked against a predictor.
// Depends on clpwm_pkg and the current_loop_iir_pwm RTL.
module current_loop_iir_pwm_tb
  import clpwm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADC_MAX       = (1 << ADC_BITS_DEF) - 1;
  localparam int NUM_REGS      = 8;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT   = 4000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASES        = 18;
  localparam int PHASE_ITEMS   = 105;

  typedef struct {
    logic [PWM_OUT_W-1:0]     pwm;
    logic                     dir;
    logic                     hit;
    logic signed [VOLT_W-1:0] volts;
  } pwm_result_t;

  class current_loop_board;
    logic [COEF_W*NUM_FBC-1:0]  fb_coefs      = '0;
    logic [COEF_W*NUM_HIST-1:0] dr_coefs      = '0;
    logic signed [VOLT_W-1:0]   ref_level     = '0;
    logic [DB_W-1:0]            deadband      = 12;
    logic [FBS_W-1:0]           fb_scale      = 53;
    logic [SAT_W-1:0]           sat_limit     = '1;
    logic [PWM_SCALE_W-1:0]     pwm_scale     = '0;
    logic [TOGGLE_W-1:0]        toggle_period = '1;
    logic [ADC_BITS_DEF-1:0]    zero_offset   = '0;
    bit                         calibrating   = 1'b1;
    logic signed [VOLT_W-1:0]   drive_hist[NUM_HIST];
    logic signed [VOLT_W-1:0]   fb_hist[NUM_HIST];
    logic [TOGGLE_W-1:0]        tick_count    = '0;
    bit                         ref_negative  = 1'b0;
    pwm_result_t                due_pwm[$];
    int                         errors        = 0;

    function new();
      foreach (drive_hist[i]) begin
        drive_hist[i] = '0;
        fb_hist[i] = '0;
      end
    endfunction

    function int pending();
      return due_pwm.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_FB_COEFS:    fb_coefs = data;
        REG_DRV_COEFS:   dr_coefs = data[COEF_W*NUM_HIST-1:0];
        REG_REF_DRIVE:   ref_level = data[VOLT_W-1:0];
        REG_DEADBAND:    deadband = data[DB_W-1:0];
        REG_FB_SCALE:    fb_scale = data[FBS_W-1:0];
        REG_SAT_LIMIT:   sat_limit = data[SAT_W-1:0];
        REG_PWM_SCALE:   pwm_scale = data[PWM_SCALE_W-1:0];
        REG_TOGGLE:      toggle_period = data[TOGGLE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint coef_of(logic [COEF_W-1:0] c);
      return longint'($signed(c));
    endfunction

    function void note_adc(logic [ADC_BITS_DEF-1:0] code);
      bit          neg_now;
      bit          hit;
      longint      diff, mag, prod, acc, drive, lim;
      logic signed [VOLT_W-1:0] fb0;
      logic [63:0] dmag, counts;
      pwm_result_t r;
      neg_now = ref_negative;
      tick_count = tick_count + 1'b1;
      if (tick_count >= toggle_period) begin
        tick_count = '0;
        ref_negative = !ref_negative;
      end
      if (calibrating) begin
        zero_offset = code;
        foreach (drive_hist[i]) begin
          drive_hist[i] = '0;
          fb_hist[i] = '0;
        end
        calibrating = 1'b0;
        return;
      end
      diff = longint'(code) - longint'(zero_offset);
      mag = (diff < 0) ? -diff : diff;
      hit = mag < longint'(deadband);
      prod = diff * longint'(fb_scale);
      if (hit) fb0 = '0;
      else if (prod > 64'sh7FFF_FFFF) fb0 = 32'sh7FFF_FFFF;
      else if (prod < -64'sh8000_0000) fb0 = 32'sh8000_0000;
      else fb0 = VOLT_W'(prod);
      acc = (neg_now ? -longint'(ref_level) : longint'(ref_level)) * 4096;
      for (int i = 0; i < NUM_HIST; i++) begin
        acc += coef_of(dr_coefs[COEF_W*i +: COEF_W]) * longint'(drive_hist[i]);
        acc += coef_of(fb_coefs[COEF_W*(i+1) +: COEF_W]) * longint'(fb_hist[i]);
      end
      acc += coef_of(fb_coefs[COEF_W-1:0]) * longint'(fb0);
      drive = (acc + 2048) >>> FRAC_SHIFT;
      lim = longint'(sat_limit);
      if (drive > lim) drive = lim;
      if (drive < -lim) drive = -lim;
      for (int i = NUM_HIST - 1; i > 0; i--) begin
        fb_hist[i] = fb_hist[i-1];
        drive_hist[i] = drive_hist[i-1];
      end
      fb_hist[0] = fb0;
      drive_hist[0] = VOLT_W'(drive);
      dmag = (drive < 0) ? -drive : drive;
      counts = (dmag * 64'(pwm_scale)) >> 32;
      if (counts > 64'd65535) counts = 64'd65535;
      r.pwm = counts[PWM_OUT_W-1:0];
      r.dir = (drive >= 0);
      r.hit = hit;
      r.volts = VOLT_W'(drive);
      due_pwm.push_back(r);
    endfunction

    function void note_miss(string field, longint want, longint got);
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endfunction

    function void check_pwm(logic [PWM_OUT_W-1:0] pwm, logic dir, logic hit,
                            logic signed [VOLT_W-1:0] volts);
      pwm_result_t want;
      if (due_pwm.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, pwm_compare %0d drive_volts %0d",
                 $time, pwm, volts);
        return;
      end
      want = due_pwm.pop_front();
      if (pwm !== want.pwm) note_miss("pwm_compare", want.pwm, pwm);
      if (dir !== want.dir) note_miss("direction", want.dir, dir);
      if (hit !== want.hit) note_miss("deadband_hit", want.hit, hit);
      if (volts !== want.volts)
        note_miss("drive_volts", longint'(want.volts), longint'(volts));
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [ADC_BITS_DEF-1:0]  adc_code_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [PWM_OUT_W-1:0]     pwm_compare_o;
  logic                     direction_o;
  logic                     deadband_hit_o;
  logic signed [VOLT_W-1:0] drive_volts_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DAT_W-1:0]     cfg_data_i;

  current_loop_board       board;
  logic [ADC_BITS_DEF-1:0] adc_offset;
  bit                      send_calm;
  bit                      recv_calm;
  int                      stall_left;
  int                      hold_left;
  int                      quiet;

  current_loop_iir_pwm #(
    .ADC_BITS(ADC_BITS_DEF)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .adc_code_i    (adc_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pwm_compare_o (pwm_compare_o),
    .direction_o   (direction_o),
    .deadband_hit_o(deadband_hit_o),
    .drive_volts_o (drive_volts_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: per-item stall draw plus an occasional long hold
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_pwm(pwm_compare_o, direction_o, deadband_hit_o, drive_volts_o);
      stall_left = recv_calm ? 0 : $urandom_range(0, 6);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value,
                           input int w);
    logic [63:0] keep;
    logic [63:0] data;
    keep = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    data = ({$urandom(), $urandom()} & ~keep) | (value & keep);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic apply_setting(input logic [63:0] fbc, input logic [47:0] dc,
                               input logic [31:0] lvl, input logic [11:0] db,
                               input logic [19:0] fbs, input logic [30:0] sat,
                               input logic [31:0] pwm, input logic [15:0] tog);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_write(REG_FB_COEFS, fbc, COEF_W*NUM_FBC);
    cfg_write(REG_DRV_COEFS, 64'(dc), COEF_W*NUM_HIST);
    cfg_write(REG_REF_DRIVE, 64'(lvl), VOLT_W);
    cfg_write(REG_DEADBAND, 64'(db), DB_W);
    cfg_write(REG_FB_SCALE, 64'(fbs), FBS_W);
    cfg_write(REG_SAT_LIMIT, 64'(sat), SAT_W);
    cfg_write(REG_PWM_SCALE, 64'(pwm), PWM_SCALE_W);
    cfg_write(REG_TOGGLE, 64'(tog), TOGGLE_W);
    cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
              {$urandom(), $urandom()}, CFG_DAT_W);
  endtask

  task automatic send_adc(input logic [ADC_BITS_DEF-1:0] code);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    adc_code_i = code;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_adc(code);
    @(negedge clk_i);
  endtask

  function automatic logic [ADC_BITS_DEF-1:0] pick_code();
    int c;
    case ($urandom_range(0, 4))
      0, 1: c = int'(adc_offset) + int'($urandom_range(0, 80)) - 40;
      2: c = ($urandom_range(0, 1) != 0) ? ADC_MAX : 0;
      default: c = int'($urandom_range(0, ADC_MAX));
    endcase
    if (c < 0) c = 0;
    if (c > ADC_MAX) c = ADC_MAX;
    return ADC_BITS_DEF'(c);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(input int reach);
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom());
      default: return 16'(int'($urandom_range(0, 2 * reach)) - reach);
    endcase
  endfunction

  function automatic logic [31:0] pick_word(input logic [31:0] top,
                                            input int unsigned modest);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return top;
      2: return $urandom() & top;
      default: return $urandom_range(0, modest) & top;
    endcase
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom();
      default: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [15:0] pick_toggle();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom());
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic random_setting();
    apply_setting({pick_coef(4096), pick_coef(4096), pick_coef(4096), pick_coef(4096)},
                  {pick_coef(1536), pick_coef(1536), pick_coef(1536)},
                  pick_level(),
                  12'(pick_word(32'h0000_0FFF, 40)),
                  20'(pick_word(32'h000F_FFFF, 4096)),
                  31'(pick_word(32'h7FFF_FFFF, 32'h0400_0000)),
                  pick_word(32'hFFFF_FFFF, 32'h0200_0000),
                  pick_toggle());
  endtask

  task automatic run_burst(input int n, input bit pause_mid);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        in_valid_i = 1'b0;
        wait_drained();
      end
      send_adc(pick_code());
    end
    in_valid_i = 1'b0;
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    adc_code_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    stall_left = 0;
    hold_left = 0;
    quiet = 0;
    adc_offset = ADC_BITS_DEF'($urandom_range(256, ADC_MAX - 256));
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // moderate loop, short toggle period; first item is the zero offset
    apply_setting({16'h8000, 16'h0100, 16'hFC00, 16'h0800}, {16'h0040, 16'hFE00, 16'h0800},
                  32'h0001_8000, 12'd12, 20'h12345, 31'h00A0_0000, 32'h0100_0000, 16'd3);
    send_adc(adc_offset);
    send_adc(adc_offset);
    send_adc(adc_offset + 12'd11);
    send_adc(adc_offset - 12'd11);
    send_adc(adc_offset + 12'd12);
    send_adc(adc_offset - 12'd12);
    send_adc('0);
    send_adc(ADC_BITS_DEF'(ADC_MAX));
    send_adc(12'h555);
    send_adc(12'hAAA);
    send_adc(12'h800);
    in_valid_i = 1'b0;

    // extremes: no dead band, feedback overflow, flip every tick
    apply_setting({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000},
                  32'h7FFF_FFFF, 12'd0, 20'hFFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    send_adc('0);
    send_adc(ADC_BITS_DEF'(ADC_MAX));
    send_adc(adc_offset);
    send_adc('0);
    send_adc(ADC_BITS_DEF'(ADC_MAX));
    send_adc(12'h555);
    in_valid_i = 1'b0;

    // zero limit, full dead band, most negative reference
    apply_setting({16'h0400, 16'hF000, 16'h0200, 16'h1000}, '0,
                  32'h8000_0000, 12'hFFF, 20'd0, 31'd0, 32'd0, 16'd1);
    send_adc(ADC_BITS_DEF'(ADC_MAX));
    send_adc('0);
    send_adc(adc_offset);
    send_adc(12'hAAA);
    in_valid_i = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      random_setting();
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      if (p == 3) begin
        send_calm = 1'b1;
        hold_left = LONG_HOLD;
      end
      run_burst(PHASE_ITEMS, p == 7);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
